>>> rtl/postfix_stack_evaluator_assert.svh
// Assertion macros for the postfix stack evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define PSE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PSE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/pse_pkg.sv
`default_nettype none
package pse_pkg;
   // Status codes reported with each result.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_DIVZERO   = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_UNKNOWN   = 3'd4;

   // ASCII symbols.
   localparam logic [7:0] SYM_ZERO  = 8'h30;
   localparam logic [7:0] SYM_NINE  = 8'h39;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_MUL   = 8'h2A;
   localparam logic [7:0] SYM_DIV   = 8'h2F;
   localparam logic [7:0] SYM_POW   = 8'h5E;

   // Operation selector for the arithmetic unit.
   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_POW
   } op_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         status;
   } rsp_type;
endpackage
`default_nettype wire

>>> rtl/pse_alu.sv
`default_nettype none
// Multicycle arithmetic unit. Add and subtract are computed at start and
// multiply in S_MUL. Divide uses restoring steps, one quotient bit a cycle.
// Power uses square and multiply, one exponent bit a cycle.
module pse_alu
   import pse_pkg::*;
#(
   parameter int VW = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire op_type        op,
   input  wire logic [VW-1:0] opa,
   input  wire logic [VW-1:0] opb,
   output logic               done,
   output logic               div_zero,
   output logic [VW-1:0]      result
);
   localparam int CW = $clog2(VW + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIV, S_POW, S_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [VW-1:0] mc_ff, mc_in;
   logic [VW-1:0] ml_ff, ml_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] base_ff, base_in;
   logic [VW-1:0] ex_ff, ex_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic          dz_ff, dz_in;
   logic [VW-1:0] res_ff, res_in;

   logic [VW-1:0] mag_a, mag_b;
   logic [VW:0]   trial;
   logic [VW-1:0] rem_sh;
   logic [VW-1:0] quo;
   logic [VW-1:0] all_ones;
   logic [VW-1:0] prod;
   logic [VW-1:0] square;

   assign all_ones = '1;
   assign mag_a    = opa[VW-1] ? (~opa + 1'b1) : opa;
   assign mag_b    = opb[VW-1] ? (~opb + 1'b1) : opb;
   assign rem_sh   = {rem_ff[VW-2:0], ml_ff[VW-1]};
   assign trial    = {1'b0, rem_sh} - {1'b0, mc_ff};
   assign quo      = {ml_ff[VW-2:0], ~trial[VW]};
   assign prod     = res_ff * base_ff;
   assign square   = base_ff * base_ff;

   // Next state of the sequencer and its datapath.
   always_comb begin
      state_in = state_ff;
      mc_in    = mc_ff;
      ml_in    = ml_ff;
      rem_in   = rem_ff;
      base_in  = base_ff;
      ex_in    = ex_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      dz_in    = dz_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dz_in = 1'b0;
               unique case (op)
                  OP_ADD: begin
                     res_in   = opa + opb;
                     state_in = S_DONE;
                  end
                  OP_SUB: begin
                     res_in   = opa - opb;
                     state_in = S_DONE;
                  end
                  OP_MUL: begin
                     res_in   = opa;
                     base_in  = opb;
                     state_in = S_MUL;
                  end
                  OP_DIV: begin
                     if (opb == '0) begin
                        dz_in    = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        rem_in   = '0;
                        ml_in    = mag_a;
                        mc_in    = mag_b;
                        neg_in   = opa[VW-1] ^ opb[VW-1];
                        cnt_in   = CW'(VW);
                        state_in = S_DIV;
                     end
                  end
                  OP_POW: begin
                     // Negative exponent gives the truncated fraction.
                     if (opb[VW-1]) begin
                        state_in = S_DONE;
                        if (opa == '0) dz_in = 1'b1;
                        else if (opa == VW'(1)) res_in = VW'(1);
                        else if (opa == all_ones) res_in = opb[0] ? all_ones : VW'(1);
                        else res_in = '0;
                     end else begin
                        res_in   = VW'(1);
                        base_in  = opa;
                        ex_in    = opb;
                        state_in = (opb == '0) ? S_DONE : S_POW;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL: begin
            res_in   = prod;
            state_in = S_DONE;
         end
         S_DIV: begin
            ml_in = quo;
            if (!trial[VW]) rem_in = trial[VW-1:0];
            else rem_in = rem_sh;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = S_DONE;
               res_in   = neg_ff ? ~quo + 1'b1 : quo;
            end
         end
         S_POW: begin
            // Multiply in the base for a set exponent bit, then square it.
            if (ex_ff[0]) res_in = prod;
            base_in = square;
            ex_in   = ex_ff >> 1;
            if ((ex_ff >> 1) == '0) state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mc_ff   <= mc_in;
      ml_ff   <= ml_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
      ex_ff   <= ex_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      dz_ff   <= dz_in;
      res_ff  <= res_in;
   end

   assign done     = (state_ff == S_DONE);
   assign div_zero = dz_ff;
   assign result   = res_ff;
endmodule
`default_nettype wire

>>> rtl/postfix_stack_evaluator.sv
// Steps: a digit goes to S_WRITE. An operator reads its operands in S_RDB,
// S_RDA and S_WAIT, runs the ALU in S_CALC (^ one exponent bit per cycle)
// and goes to S_WRITE. A final symbol then reports in S_EMIT. Only one
// transaction is handled at a time; after an error, symbols are skipped.
// The divider and the exponent loop set the worst case; a waiting result only
// stalls input once the next result is ready. Reset clears the stack pointer
// and error code, not the stack RAM.
`default_nettype none
`include "postfix_stack_evaluator_assert.svh"
module postfix_stack_evaluator
   import pse_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam int VW = VALUE_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE, S_RDB, S_RDA, S_WAIT, S_CALC, S_WRITE, S_EMIT
   } state_type;

   state_type     state_ff;
   logic [PW-1:0] sp_ff;
   logic [2:0]    err_ff;
   logic          last_ff;
   op_type        op_ff;
   logic [VW-1:0] b_ff;
   logic [VW-1:0] a_ff;
   logic [VW-1:0] wdata_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   // Stack memory, one read port and one write port, registered read.
   logic [VW-1:0] mem [STACK_DEPTH];
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [VW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata_ff;
      rdata_ff <= mem[raddr];
   end

   logic          alu_start, alu_done, alu_dz;
   logic [VW-1:0] alu_res;

   pse_alu #(.VW(VW)) u_alu (
      .clock    (clock),
      .reset    (reset),
      .start    (alu_start),
      .op       (op_ff),
      .opa      (a_ff),
      .opb      (b_ff),
      .done     (alu_done),
      .div_zero (alu_dz),
      .result   (alu_res)
   );

   logic is_digit, is_op;
   op_type dec_op;
   always_comb begin
      is_digit = (req_data.symbol >= SYM_ZERO) && (req_data.symbol <= SYM_NINE);
      is_op    = 1'b1;
      dec_op   = OP_ADD;
      unique case (req_data.symbol)
         SYM_PLUS:  dec_op = OP_ADD;
         SYM_MINUS: dec_op = OP_SUB;
         SYM_MUL:   dec_op = OP_MUL;
         SYM_DIV:   dec_op = OP_DIV;
         SYM_POW:   dec_op = OP_POW;
         default:   is_op  = 1'b0;
      endcase
   end

   logic accept;
   logic emit_go;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign we        = (state_ff == S_WRITE);
   assign waddr     = sp_ff[AW-1:0];
   assign raddr     = (state_ff == S_RDB) ? AW'(sp_ff - 1'b1)
                                          : AW'(sp_ff - PW'(2));
   assign alu_start = (state_ff == S_CALC);

   logic [VW-1:0] digit_val;
   assign digit_val = VW'(req_data.symbol - SYM_ZERO);

   // Sequencer: accept, read operands, compute, write back, report.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_go) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  last_ff <= req_data.last;
                  op_ff   <= dec_op;
                  if (err_ff != ST_OK) begin
                     state_ff <= req_data.last ? S_RDB : S_IDLE;
                  end else if (is_digit) begin
                     if (sp_ff >= PW'(STACK_DEPTH)) begin
                        err_ff   <= ST_OVERFLOW;
                        state_ff <= req_data.last ? S_RDB : S_IDLE;
                     end else begin
                        wdata_ff <= digit_val;
                        state_ff <= S_WRITE;
                     end
                  end else if (!is_op) begin
                     err_ff   <= ST_UNKNOWN;
                     state_ff <= req_data.last ? S_RDB : S_IDLE;
                  end else if (sp_ff < PW'(2)) begin
                     err_ff   <= ST_UNDERFLOW;
                     state_ff <= req_data.last ? S_RDB : S_IDLE;
                  end else begin
                     state_ff <= S_RDB;
                  end
               end
            end
            S_RDB: begin
               // Also entered for a final symbol after an error, on the way to the report.
               state_ff <= S_RDA;
            end
            S_RDA: begin
               b_ff     <= rdata_ff;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               // Only an operator or a final symbol after an error gets here.
               a_ff <= rdata_ff;
               if (err_ff != ST_OK) state_ff <= S_EMIT;
               else state_ff <= S_CALC;
            end
            S_CALC: begin
               if (alu_done) begin
                  sp_ff <= sp_ff - PW'(2);
                  if (alu_dz) begin
                     err_ff   <= ST_DIVZERO;
                     state_ff <= last_ff ? S_EMIT : S_IDLE;
                  end else begin
                     wdata_ff <= alu_res;
                     state_ff <= S_WRITE;
                  end
               end
            end
            S_WRITE: begin
               sp_ff    <= sp_ff + 1'b1;
               b_ff     <= wdata_ff;
               state_ff <= last_ff ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               // The report waits until the result register is free.
               if (emit_go) begin
                  if (err_ff != ST_OK) begin
                     rsp_ff.value  <= '0;
                     rsp_ff.status <= err_ff;
                  end else if (sp_ff == '0) begin
                     rsp_ff.value  <= '0;
                     rsp_ff.status <= ST_UNDERFLOW;
                  end else begin
                     rsp_ff.value  <= 32'(signed'(b_ff));
                     rsp_ff.status <= ST_OK;
                  end
                  sp_ff    <= '0;
                  err_ff   <= ST_OK;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PSE_ASSERT_IMP(a_sp_range, clock, reset, 1'b1, sp_ff <= PW'(STACK_DEPTH),
                   "stack pointer beyond depth")
   `PSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff,
                    "result dropped while stalled")
   `PSE_ASSERT_NEXT(a_emit_clears, clock, reset, emit_go,
                    sp_ff == '0 && err_ff == ST_OK && rsp_valid_ff,
                    "report did not clear the stack")
endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import pse_pkg::*;

   localparam int DEPTH = 64;
   localparam int CYCLE_LIMIT = 3000000;

   // Scoreboard: an expression predictor plus a queue of expected responses.
   class expr_scoreboard;
      logic [31:0] stack_mem[DEPTH];
      int          depth_used;
      logic [2:0]  err_code;
      rsp_type     pending[$];
      int          failures;

      function void clear();
         depth_used = 0;
         err_code = ST_OK;
         pending.delete();
         failures = 0;
      endfunction

      // Truncating signed division; the divisor is nonzero.
      function logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
         logic [31:0] ma, mb, q;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         q = ma / mb;
         return (a[31] != b[31]) ? -q : q;
      endfunction

      // Applies one symbol to the predicted stack.
      function void apply_symbol(logic [7:0] sym);
         logic [31:0] a, b, r, base, ex;
         if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
            if (depth_used >= DEPTH) begin
               err_code = ST_OVERFLOW;
               return;
            end
            stack_mem[depth_used] = {24'd0, sym - SYM_ZERO};
            depth_used++;
            return;
         end
         if (sym != SYM_PLUS && sym != SYM_MINUS && sym != SYM_MUL &&
             sym != SYM_DIV && sym != SYM_POW) begin
            err_code = ST_UNKNOWN;
            return;
         end
         if (depth_used < 2) begin
            err_code = ST_UNDERFLOW;
            return;
         end
         b = stack_mem[depth_used - 1];
         a = stack_mem[depth_used - 2];
         depth_used -= 2;
         case (sym)
            SYM_PLUS: r = a + b;
            SYM_MINUS: r = a - b;
            SYM_MUL: r = a * b;
            SYM_DIV: begin
               if (b == 0) begin
                  err_code = ST_DIVZERO;
                  return;
               end
               r = div_trunc(a, b);
            end
            default: begin
               if (b[31]) begin
                  if (a == 0) begin
                     err_code = ST_DIVZERO;
                     return;
                  end
                  if (a == 1) r = 1;
                  else if (a == '1) r = b[0] ? '1 : 32'd1;
                  else r = 0;
               end else begin
                  r = 1;
                  base = a;
                  ex = b;
                  while (ex != 0) begin
                     if (ex[0]) r = r * base;
                     base = base * base;
                     ex = ex >> 1;
                  end
               end
            end
         endcase
         stack_mem[depth_used] = r;
         depth_used++;
      endfunction

      // Notes one accepted request transaction.
      function void note_request(req_type req);
         rsp_type rsp;
         if (err_code == ST_OK) apply_symbol(req.symbol);
         if (!req.last) return;
         rsp.status = err_code;
         rsp.value = 0;
         if (err_code == ST_OK) begin
            if (depth_used == 0) rsp.status = ST_UNDERFLOW;
            else rsp.value = stack_mem[depth_used - 1];
         end
         pending.push_back(rsp);
         depth_used = 0;
         err_code = ST_OK;
      endfunction

      // Checks one accepted response transaction against the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         if (pending.size() == 0) begin
            $error("unexpected response value=%0d status=%0d", got.value, got.status);
            failures++;
            return;
         end
         exp_rsp = pending.pop_front();
         if (got.value !== exp_rsp.value) begin
            $error("value: expected %0d, actual %0d", exp_rsp.value, got.value);
            failures++;
         end
         if (got.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, got.status);
            failures++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   expr_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int cycle_count;
   logic [7:0] op_syms[5];

   postfix_stack_evaluator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
      end
   end

   // Response-side stall generator, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Drives one request transaction and waits for its acceptance.
   task automatic send_symbol(logic [7:0] sym, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.symbol = sym;
      req_data.last = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // Random digit biased toward nine.
   function automatic logic [7:0] rand_digit();
      return SYM_ZERO + (($urandom_range(3) == 0) ? 8'd9 : 8'($urandom_range(9)));
   endfunction

   // One well-formed expression with random content, occasionally broken.
   task automatic send_expression();
      int n;
      int held;
      int kind;
      n = $urandom_range(1, 6);
      held = 0;
      send_symbol(rand_digit(), 1'b0);
      held = 1;
      for (int i = 0; i < 2 * n; i++) begin
         kind = $urandom_range(99);
         if (kind < 3) begin
            send_symbol(8'($urandom), 1'b0);
         end else if (held >= 2 && (kind < 50 || i >= n)) begin
            send_symbol(op_syms[$urandom_range(4)], 1'b0);
            held--;
         end else if (held < 2 || kind < 97) begin
            send_symbol(rand_digit(), 1'b0);
            held++;
         end else begin
            send_symbol(op_syms[$urandom_range(4)], 1'b0);
         end
      end
      send_symbol(($urandom_range(9) == 0) ? 8'($urandom) : op_syms[$urandom_range(4)],
                  1'b1);
   endtask

   initial begin
      op_syms = '{SYM_PLUS, SYM_MINUS, SYM_MUL, SYM_DIV, SYM_POW};
      board = new();
      board.clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      hold_cycles = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes and special cases.
      send_symbol(SYM_NINE, 1'b1);
      send_symbol(SYM_PLUS, 1'b1);
      send_symbol(SYM_ZERO, 1'b0);
      send_symbol(SYM_ZERO, 1'b0);
      send_symbol(SYM_DIV, 1'b1);
      send_symbol(SYM_ZERO, 1'b0);
      send_symbol(SYM_ZERO, 1'b0);
      send_symbol(SYM_POW, 1'b1);
      send_symbol(8'hFF, 1'b0);
      send_symbol(SYM_NINE, 1'b1);
      send_symbol(SYM_ZERO, 1'b0);
      send_symbol(SYM_ZERO + 8'd1, 1'b0);
      send_symbol(SYM_MINUS, 1'b0);
      send_symbol(SYM_ZERO, 1'b0);
      send_symbol(SYM_POW, 1'b1);
      send_symbol(SYM_NINE, 1'b0);
      send_symbol(SYM_NINE, 1'b0);
      send_symbol(SYM_MUL, 1'b1);
      drain();

      // Full stack: push until overflow.
      for (int i = 0; i <= DEPTH; i++) send_symbol(rand_digit(), 1'b0);
      send_symbol(SYM_NINE, 1'b1);
      drain();

      // Negative value divided by minus one: (2 - 9^5) / (0 - 1).
      send_symbol(SYM_ZERO, 1'b0);
      send_symbol(8'h32, 1'b0);
      send_symbol(8'h39, 1'b0);
      send_symbol(8'h33, 1'b0);
      send_symbol(SYM_ZERO + 8'd1, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);
      send_symbol(SYM_ZERO + 8'd1, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);
      send_symbol(SYM_POW, 1'b0);
      send_symbol(SYM_MINUS, 1'b0);
      send_symbol(SYM_ZERO, 1'b0);
      send_symbol(SYM_ZERO + 8'd1, 1'b0);
      send_symbol(SYM_MINUS, 1'b0);
      send_symbol(SYM_DIV, 1'b1);
      drain();

      // Pressure: receiver holds off while the sender keeps offering.
      hold_cycles = 2000;
      for (int i = 0; i < 10; i++) send_expression();
      drain();

      // Random phases with changing idle rates.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
         recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 31 : 0;
         for (int i = 0; i < 60; i++) begin
            if ($urandom_range(19) == 0) send_symbol(8'($urandom), 1'($urandom));
            else send_expression();
         end
         drain();
      end

      if (board.failures == 0 && board.pending.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> postfix_stack_evaluator.f
+incdir+rtl
rtl/pse_pkg.sv
rtl/pse_alu.sv
rtl/postfix_stack_evaluator.sv
verif/tb.sv
